>>> hw/rtl/prcd_pkg.sv
// prcd_pkg: shared types, constants and matching functions for the
// pulse-width remote code decoder. No dependencies.

package prcd_pkg;

    localparam int DurW  = 24;
    localparam int MagW  = 23;
    localparam int TimeW = 16;
    localparam int LenW  = 6;
    localparam int CodeW = 32;

    typedef logic signed [DurW-1:0] dur_t;
    typedef logic [MagW-1:0]        mag_t;
    typedef logic [TimeW-1:0]       time_t;
    typedef logic [LenW-1:0]        len_t;
    typedef logic [CodeW-1:0]       code_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SHORT_TIME  = 2'd0,
        REG_LONG_TIME   = 2'd1,
        REG_TOLERANCE   = 2'd2,
        REG_CODE_LENGTH = 2'd3
    } cfg_reg_t;

    localparam time_t SHORT_TIME_RST  = 16'd555;
    localparam time_t LONG_TIME_RST   = 16'd1111;
    localparam time_t TOLERANCE_RST   = 16'd200;
    localparam len_t  CODE_LENGTH_RST = 6'd12;

    localparam dur_t DUR_MIN = {1'b1, {(DurW-1){1'b0}}};

    // magnitude of a signed duration, saturating at the most negative value
    function automatic mag_t magnitude(dur_t d);
        logic [DurW-1:0] neg;
        neg = ~d + 1'b1;
        if (!d[DurW-1])
            return d[MagW-1:0];
        else if (d == DUR_MIN)
            return {MagW{1'b1}};
        else
            return neg[MagW-1:0];
    endfunction

    // true when mag lies within nominal +/- tol, lower bound clamped at zero
    function automatic logic in_window(mag_t mag, time_t nominal, time_t tol);
        logic [TimeW:0] hi;
        logic           lo_ok;
        logic           hi_ok;
        hi    = {1'b0, nominal} + {1'b0, tol};
        lo_ok = (tol >= nominal) || (mag >= MagW'(nominal - tol));
        hi_ok = mag <= MagW'(hi);
        return lo_ok && hi_ok;
    endfunction

endpackage

>>> hw/rtl/prcd_in_if.sv
// prcd_in_if: duration input channel, valid/ready with one duration word.
// Depends on prcd_pkg.

interface prcd_in_if;
    logic           valid;
    logic           ready;
    prcd_pkg::dur_t duration;
    logic           first_item;
    logic           last_item;

    modport source (output valid, output duration, output first_item,
                    output last_item, input ready);
    modport sink   (input valid, input duration, input first_item,
                    input last_item, output ready);
endinterface

>>> hw/rtl/prcd_out_if.sv
// prcd_out_if: result channel, valid/ready with found flag and code.
// Depends on prcd_pkg.

interface prcd_out_if;
    logic            valid;
    logic            ready;
    logic            found;
    prcd_pkg::code_t code;

    modport source (output valid, output found, output code, input ready);
    modport sink   (input valid, input found, input code, output ready);
endinterface

>>> hw/rtl/prcd_cfg_if.sv
// prcd_cfg_if: configuration write channel, register index and data.
// Depends on prcd_pkg.

interface prcd_cfg_if;
    logic               valid;
    logic               ready;
    prcd_pkg::cfg_reg_t index;
    prcd_pkg::time_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pwm_remote_code_decoder.sv
// pwm_remote_code_decoder: pairs pulse/gap durations into PWM bits and emits codes.
// Depends on prcd_pkg, prcd_in_if, prcd_out_if, prcd_cfg_if.
//
//   port    | direction | word
//   --------+-----------+-------------------------------------------
//   item    | sink      | duration, first_item, last_item
//   result  | source    | found, code
//   cfg     | sink      | index, data (register write)
//
// one word per cycle sustained while each result is taken; a word goes to the input register, then the result register
// an input register feeds one pass of window compares into the result register
// the input register keeps taking words while the result register is full
// and not yet taken, until the input register itself is full
// rst_n restores the default timing and an open, empty capture

module pwm_remote_code_decoder (
    input  logic        clk,
    input  logic        rst_n,
    prcd_in_if.sink     item,
    prcd_out_if.source  result,
    prcd_cfg_if.sink    cfg
);

    prcd_pkg::time_t short_time_reg;
    prcd_pkg::time_t long_time_reg;
    prcd_pkg::time_t tolerance_reg;
    prcd_pkg::len_t  code_length_reg;

    logic            in_valid_reg;
    logic            in_valid_next;
    prcd_pkg::dur_t  in_dur_reg;
    logic            in_first_reg;
    logic            in_last_reg;

    logic            expect_gap_reg;
    logic            expect_gap_next;
    prcd_pkg::mag_t  held_pulse_reg;
    prcd_pkg::mag_t  held_pulse_next;
    prcd_pkg::code_t shift_code_reg;
    prcd_pkg::code_t shift_code_next;
    prcd_pkg::len_t  bit_total_reg;
    prcd_pkg::len_t  bit_total_next;
    logic            closed_reg;
    logic            closed_next;

    logic            res_valid_reg;
    logic            res_valid_next;
    logic            res_found_reg;
    prcd_pkg::code_t res_code_reg;

    logic            advance;
    logic            fire;
    logic            emit;
    logic            emit_found;
    prcd_pkg::code_t emit_code;
    logic            done;

    prcd_pkg::mag_t  gap_mag;
    logic            is_zero;
    logic            is_one;

    assign advance    = !res_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign result.valid = res_valid_reg;
    assign result.found = res_found_reg;
    assign result.code  = res_code_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_time_reg  <= prcd_pkg::SHORT_TIME_RST;
            long_time_reg   <= prcd_pkg::LONG_TIME_RST;
            tolerance_reg   <= prcd_pkg::TOLERANCE_RST;
            code_length_reg <= prcd_pkg::CODE_LENGTH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                prcd_pkg::REG_SHORT_TIME:  short_time_reg  <= cfg.data;
                prcd_pkg::REG_LONG_TIME:   long_time_reg   <= cfg.data;
                prcd_pkg::REG_TOLERANCE:   tolerance_reg   <= cfg.data;
                prcd_pkg::REG_CODE_LENGTH: code_length_reg <= cfg.data[prcd_pkg::LenW-1:0];
                default: ;
            endcase
        end
    end

    // bit decision from the held pulse and the current gap
    assign gap_mag = prcd_pkg::magnitude(in_dur_reg);
    assign is_zero = prcd_pkg::in_window(held_pulse_reg, short_time_reg, tolerance_reg)
                  && prcd_pkg::in_window(gap_mag, long_time_reg, tolerance_reg);
    assign is_one  = prcd_pkg::in_window(held_pulse_reg, long_time_reg, tolerance_reg)
                  && prcd_pkg::in_window(gap_mag, short_time_reg, tolerance_reg);

    always_comb
    begin
        expect_gap_next = expect_gap_reg;
        held_pulse_next = held_pulse_reg;
        shift_code_next = shift_code_reg;
        bit_total_next  = bit_total_reg;
        closed_next     = closed_reg;
        emit            = 1'b0;
        emit_found      = 1'b0;
        emit_code       = '0;
        done            = 1'b0;

        if (in_first_reg)
        begin
            expect_gap_next = 1'b0;
            shift_code_next = '0;
            bit_total_next  = '0;
            closed_next     = 1'b0;
        end

        if (!closed_next)
        begin
            if (!expect_gap_next)
            begin
                if (in_dur_reg[prcd_pkg::DurW-1])
                begin
                    // a leading gap is skipped, a gap in pulse position fails
                    if (!in_first_reg)
                    begin
                        closed_next = 1'b1;
                        emit        = 1'b1;
                        done        = 1'b1;
                    end
                end
                else
                begin
                    held_pulse_next = in_dur_reg[prcd_pkg::MagW-1:0];
                    expect_gap_next = 1'b1;
                end
            end
            else
            begin
                expect_gap_next = 1'b0;
                if (is_zero || is_one)
                begin
                    shift_code_next = {shift_code_next[prcd_pkg::CodeW-2:0], !is_zero};
                    bit_total_next  = bit_total_next + 1'b1;
                    if (bit_total_next == code_length_reg)
                    begin
                        closed_next = 1'b1;
                        emit        = 1'b1;
                        emit_found  = 1'b1;
                        emit_code   = shift_code_next;
                        done        = 1'b1;
                    end
                end
                else
                begin
                    shift_code_next = '0;
                    bit_total_next  = '0;
                end
            end

            if (!done && in_last_reg)
            begin
                closed_next = 1'b1;
                emit        = 1'b1;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.valid && item.ready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (res_valid_reg && result.ready)
            res_valid_next = 1'b0;
        if (fire)
            res_valid_next = emit;
    end

    // control and capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            expect_gap_reg <= 1'b0;
            held_pulse_reg <= '0;
            shift_code_reg <= '0;
            bit_total_reg  <= '0;
            closed_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                expect_gap_reg <= expect_gap_next;
                held_pulse_reg <= held_pulse_next;
                shift_code_reg <= shift_code_next;
                bit_total_reg  <= bit_total_next;
                closed_reg     <= closed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_dur_reg   <= item.duration;
            in_first_reg <= item.first_item;
            in_last_reg  <= item.last_item;
        end
        if (fire && emit)
        begin
            res_found_reg <= emit_found;
            res_code_reg  <= emit_code;
        end
    end

`ifndef SYNTH
    a_fail_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.code == '0)
        else $error("fail word carries a non-zero code");

    a_in_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && res_valid_reg && !result.ready |=> in_valid_reg)
        else $error("input word dropped while result stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> item.ready)
        else $error("input register empty but not ready");
`endif

endmodule
